// File: rtl/mscf_pkg.sv
package mscf_pkg;

   localparam int DUTY_W    = 9;
   localparam int SPEED_W   = 16;
   localparam int ADC_W     = 16;
   localparam int GAIN_W    = 17;
   localparam int CUR_W     = 22;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   localparam int DUTY_MAX  = 400;

   // shared multiplier operands and product
   localparam int MUL_A_W   = 23;
   localparam int MUL_B_W   = 22;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int FRAC_W    = 16;

   localparam logic signed [MUL_B_W-1:0] SCALE_Q16 = 22'sd1609170;
   localparam logic signed [CUR_W+1:0]   CUR_LIMIT = 24'sd1609216;
   localparam logic [GAIN_W-1:0]         GAIN_ONE  = 17'h10000;
   localparam logic signed [PROD_W-1:0]  RND_HALF  = 45'sd32768;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 2'd2;

   // item commands
   localparam logic CMD_SPEED   = 1'b0;
   localparam logic CMD_CURRENT = 1'b1;

endpackage

// File: rtl/mscf_mul.sv
module mscf_mul (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [mscf_pkg::MUL_A_W-1:0]   a,
   input  logic signed [mscf_pkg::MUL_B_W-1:0]   b,
   output logic signed [mscf_pkg::PROD_W-1:0]    p
);
   import mscf_pkg::*;

   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] p_in;

   assign p_in = PROD_W'(a) * PROD_W'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// File: rtl/motor_speed_and_current_filter_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  cmd, motor_sel, speed_req, adc_sample
// rsp_      out        rsp_valid / rsp_stall  result_kind, motor_out, duty, reverse,
//                                             current_filtered
// csr_      in         csr_wr_en              csr_index, csr_wdata
//
// Speed item: the result is formed in ST_OUT and loaded into the output register.
// Current item: ST_MUL1, ST_SUB, ST_MUL2, ST_FIN, then ST_OUT; two passes through the one
// shared multiplier (scale, then filter gain), each product rounded before the subtract or add.
// One item at a time; req_stall is high from acceptance until the result is
// loaded into the output register, which then holds while rsp_stall is high.
// Synchronous reset: offsets 0, gain 1.0, both motors forward, filter state 0.
module motor_speed_and_current_filter_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic                                   req_motor_sel,
   input  logic signed [mscf_pkg::SPEED_W-1:0]    req_speed_req,
   input  logic [mscf_pkg::ADC_W-1:0]             req_adc_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_result_kind,
   output logic                                   rsp_motor_out,
   output logic [mscf_pkg::DUTY_W-1:0]            rsp_duty,
   output logic                                   rsp_reverse,
   output logic signed [mscf_pkg::CUR_W-1:0]      rsp_current_filtered,
   input  logic                                   csr_wr_en,
   input  logic [mscf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mscf_pkg::CSR_DAT_W-1:0]         csr_wdata
);
   import mscf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_SUB  = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [ADC_W-1:0]           off_a_ff, off_b_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic                       dir_ff [2];
   logic signed [CUR_W-1:0]    cur_ff [2];

   logic                       cmd_ff, sel_ff;
   logic signed [SPEED_W-1:0]  speed_ff;
   logic [ADC_W-1:0]           adc_ff;
   logic signed [MUL_A_W-1:0]  d_ff, d_in;
   logic signed [CUR_W-1:0]    y_ff, y_in;

   logic                       rsp_valid_ff;
   logic                       kind_ff, mot_ff, rev_ff;
   logic [DUTY_W-1:0]          duty_ff;
   logic signed [CUR_W-1:0]    curf_ff;

   logic                       accept, out_free, mul_en;
   logic [ADC_W-1:0]           off_sel;
   logic [GAIN_W-1:0]          gain_sat;
   logic signed [ADC_W:0]      diff, diff_adj;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod, rsum, rsh;
   logic signed [CUR_W-1:0]    x, y_cur;
   logic signed [CUR_W+1:0]    ysum;
   logic                       spd_neg, rev_new;
   logic [SPEED_W:0]           mag;
   logic [DUTY_W-1:0]          duty_new;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // current path
   assign off_sel  = sel_ff ? off_b_ff : off_a_ff;
   assign gain_sat = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
   assign diff     = $signed({1'b0, adc_ff}) - $signed({1'b0, off_sel});
   assign diff_adj = dir_ff[sel_ff] ? -diff : diff;
   assign y_cur    = cur_ff[sel_ff];

   assign mul_en = (state_ff == ST_MUL1) || (state_ff == ST_MUL2);
   assign mul_a  = (state_ff == ST_MUL1) ? MUL_A_W'(diff_adj) : d_ff;
   assign mul_b  = (state_ff == ST_MUL1) ? SCALE_Q16 : MUL_B_W'($signed({1'b0, gain_sat}));

   mscf_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   // round to nearest, halves up
   assign rsum = prod + RND_HALF;
   assign rsh  = rsum >>> FRAC_W;
   assign x    = rsh[CUR_W-1:0];
   assign d_in = MUL_A_W'(x) - MUL_A_W'(y_cur);
   assign ysum = (CUR_W+2)'(y_cur) + rsh[CUR_W+1:0];

   always_comb begin
      priority if (ysum > CUR_LIMIT) begin
         y_in = CUR_LIMIT[CUR_W-1:0];
      end else if (ysum < -CUR_LIMIT) begin
         y_in = CUR_W'(-CUR_LIMIT);
      end else begin
         y_in = ysum[CUR_W-1:0];
      end
   end

   // speed path
   assign spd_neg  = speed_ff[SPEED_W-1];
   assign mag      = spd_neg ? (SPEED_W+1)'(-(SPEED_W+1)'(speed_ff))
                             : (SPEED_W+1)'(speed_ff);
   assign duty_new = (mag > (SPEED_W+1)'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : mag[DUTY_W-1:0];
   assign rev_new  = spd_neg;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == CMD_CURRENT) ? ST_MUL1 : ST_OUT;
            end
         end
         ST_MUL1: state_in = ST_SUB;
         ST_SUB:  state_in = ST_MUL2;
         ST_MUL2: state_in = ST_FIN;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         off_a_ff     <= '0;
         off_b_ff     <= '0;
         gain_ff      <= GAIN_ONE;
         dir_ff[0]    <= 1'b0;
         dir_ff[1]    <= 1'b0;
         cur_ff[0]    <= '0;
         cur_ff[1]    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_OFFSET_A: off_a_ff <= csr_wdata[ADC_W-1:0];
               CSR_OFFSET_B: off_b_ff <= csr_wdata[ADC_W-1:0];
               CSR_GAIN:     gain_ff  <= csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_FIN) begin
            cur_ff[sel_ff] <= y_in;
         end
         if (state_ff == ST_OUT && out_free && cmd_ff == CMD_SPEED) begin
            dir_ff[sel_ff] <= rev_new;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         sel_ff   <= req_motor_sel;
         speed_ff <= req_speed_req;
         adc_ff   <= req_adc_sample;
      end
      if (state_ff == ST_SUB) begin
         d_ff <= d_in;
      end
      if (state_ff == ST_FIN) begin
         y_ff <= y_in;
      end
      if (state_ff == ST_OUT && out_free) begin
         kind_ff <= cmd_ff;
         mot_ff  <= sel_ff;
         if (cmd_ff == CMD_SPEED) begin
            duty_ff <= duty_new;
            rev_ff  <= rev_new;
            curf_ff <= '0;
         end else begin
            duty_ff <= '0;
            rev_ff  <= dir_ff[sel_ff];
            curf_ff <= y_ff;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_motor_out        = mot_ff;
   assign rsp_duty             = duty_ff;
   assign rsp_reverse          = rev_ff;
   assign rsp_current_filtered = curf_ff;

endmodule

// File: verif/tb_motor_speed_and_current_filter_core.sv
`timescale 1ns / 100ps

typedef struct packed {
   bit                        cmd;
   bit                        motor;
   bit [mscf_pkg::SPEED_W-1:0] speed;
   bit [mscf_pkg::ADC_W-1:0]   adc;
} drive_req_type;

typedef struct packed {
   bit                        kind;
   bit                        motor;
   bit [mscf_pkg::DUTY_W-1:0] duty;
   bit                        reverse;
   bit [mscf_pkg::CUR_W-1:0]  current;
} drive_rsp_type;

class motor_filter_scoreboard;
   bit [mscf_pkg::ADC_W-1:0]  offset [2];
   bit [mscf_pkg::GAIN_W-1:0] gain;
   bit                        reversed [2];
   longint                    y_state [2];
   drive_rsp_type             expected_results [$];
   int                        mismatches;
   int                        n_speed;
   int                        n_current;
   int                        n_checked;

   function new();
      offset[0]   = '0;
      offset[1]   = '0;
      gain        = mscf_pkg::GAIN_ONE;
      reversed[0] = 1'b0;
      reversed[1] = 1'b0;
      y_state[0]  = 0;
      y_state[1]  = 0;
      mismatches  = 0;
      n_speed     = 0;
      n_current   = 0;
      n_checked   = 0;
   endfunction

   function void write_reg(bit [mscf_pkg::CSR_IDX_W-1:0] idx,
                           bit [mscf_pkg::CSR_DAT_W-1:0] val);
      case (idx)
         mscf_pkg::CSR_OFFSET_A: offset[0] = val[mscf_pkg::ADC_W-1:0];
         mscf_pkg::CSR_OFFSET_B: offset[1] = val[mscf_pkg::ADC_W-1:0];
         mscf_pkg::CSR_GAIN:     gain = val;
         default: ;
      endcase
   endfunction

   // floor((v + half) / 2^16)
   function longint round_q16(longint v);
      return (v + 64'sd32768) >>> mscf_pkg::FRAC_W;
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   function void note_request(drive_req_type r);
      drive_rsp_type e;
      longint     s, mag, diff, x, g, y, lim;
      int         m;
      m         = r.motor;
      e.kind    = r.cmd;
      e.motor   = r.motor;
      e.duty    = '0;
      e.reverse = 1'b0;
      e.current = '0;
      if (r.cmd == mscf_pkg::CMD_SPEED) begin
         n_speed++;
         s   = longint'($signed(r.speed));
         mag = (s < 0) ? -s : s;
         if (mag > mscf_pkg::DUTY_MAX)
            mag = mscf_pkg::DUTY_MAX;
         e.reverse   = (s < 0);
         e.duty      = mag[mscf_pkg::DUTY_W-1:0];
         reversed[m] = e.reverse;
      end else begin
         n_current++;
         diff = longint'(r.adc) - longint'(offset[m]);
         if (reversed[m])
            diff = -diff;
         x   = round_q16(diff * longint'(mscf_pkg::SCALE_Q16));
         g   = (gain > mscf_pkg::GAIN_ONE) ? longint'(mscf_pkg::GAIN_ONE) : longint'(gain);
         y   = y_state[m] + round_q16(g * (x - y_state[m]));
         lim = longint'(mscf_pkg::CUR_LIMIT);
         if (y > lim)
            y = lim;
         if (y < -lim)
            y = -lim;
         y_state[m] = y;
         e.reverse  = reversed[m];
         e.current  = y[mscf_pkg::CUR_W-1:0];
      end
      expected_results.push_back(e);
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task check_response(drive_rsp_type got);
      drive_rsp_type e;
      if (expected_results.size() == 0) begin
         report_mismatch("result item with nothing expected");
         return;
      end
      e = expected_results.pop_front();
      n_checked++;
      if (got.kind != e.kind)
         report_mismatch($sformatf("result_kind got %0d exp %0d", got.kind, e.kind));
      if (got.motor != e.motor)
         report_mismatch($sformatf("motor_out got %0d exp %0d", got.motor, e.motor));
      if (got.duty != e.duty)
         report_mismatch($sformatf("duty got %0d exp %0d", got.duty, e.duty));
      if (got.reverse != e.reverse)
         report_mismatch($sformatf("reverse got %0d exp %0d", got.reverse, e.reverse));
      if (got.current != e.current)
         report_mismatch($sformatf("current_filtered got %0d exp %0d",
                                   $signed(got.current), $signed(e.current)));
   endtask
endclass

module tb_motor_speed_and_current_filter_core;
   import mscf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 60;
   localparam int N_PHASES       = 6;
   localparam int PHASE_ITEMS    = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_cmd;
   logic                        req_motor_sel;
   logic signed [SPEED_W-1:0]   req_speed_req;
   logic [ADC_W-1:0]            req_adc_sample;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_result_kind;
   logic                        rsp_motor_out;
   logic [DUTY_W-1:0]           rsp_duty;
   logic                        rsp_reverse;
   logic signed [CUR_W-1:0]     rsp_current_filtered;
   logic                        csr_wr_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DAT_W-1:0]        csr_wdata;

   bit req_idle_on;
   bit rsp_idle_on;
   bit long_hold_req;
   int n_settings;

   motor_filter_scoreboard sb = new();

   motor_speed_and_current_filter_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_motor_sel        (req_motor_sel),
      .req_speed_req        (req_speed_req),
      .req_adc_sample       (req_adc_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_motor_out        (rsp_motor_out),
      .rsp_duty             (rsp_duty),
      .rsp_reverse          (rsp_reverse),
      .rsp_current_filtered (rsp_current_filtered),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request('{req_cmd, req_motor_sel, req_speed_req, req_adc_sample});
         if (rsp_valid && !rsp_stall)
            sb.check_response('{rsp_result_kind, rsp_motor_out, rsp_duty, rsp_reverse,
                                rsp_current_filtered});
      end
   end

   // result side back-pressure
   initial begin
      int burst_left;
      int hold_left;
      burst_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(1, 16) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset === 1'b1 || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("[motor_speed_and_current_filter_core] ERROR");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send(input bit c, input bit m, input bit [SPEED_W-1:0] s,
                       input bit [ADC_W-1:0] a);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= c;
      req_motor_sel  <= m;
      req_speed_req  <= s;
      req_adc_sample <= a;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (sb.pending() != 0);
   endtask

   task automatic configure(input bit [CSR_DAT_W-1:0] off_a, input bit [CSR_DAT_W-1:0] off_b,
                            input bit [CSR_DAT_W-1:0] g);
      logic [CSR_IDX_W-1:0] idx  [4];
      bit   [CSR_DAT_W-1:0] vals [4];
      idx  = '{CSR_OFFSET_A, CSR_OFFSET_B, CSR_GAIN, CSR_UNUSED};
      vals = '{off_a, off_b, g, CSR_DAT_W'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         sb.write_reg(idx[i], vals[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   initial begin
      bit [CSR_DAT_W-1:0] gain_val;
      bit                 c;
      bit                 m;
      bit [SPEED_W-1:0]   s;
      bit [ADC_W-1:0]     a;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_SPEED;
      req_motor_sel  = 1'b0;
      req_speed_req  = '0;
      req_adc_sample = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_OFFSET_A;
      csr_wdata      = '0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      long_hold_req  = 1'b0;
      n_settings     = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // speed extremes, clamping, zero speed, both motors
      send(CMD_SPEED,   1'b0, 16'sd0,      16'hFFFF);
      send(CMD_SPEED,   1'b0, 16'sd400,    16'h0000);
      send(CMD_SPEED,   1'b0, 16'sd401,    16'h5A5A);
      send(CMD_SPEED,   1'b0, 16'sd32767,  16'hA5A5);
      send(CMD_SPEED,   1'b0, -16'sd32768, 16'h0001);
      send(CMD_SPEED,   1'b0, -16'sd1,     16'h8000);
      send(CMD_SPEED,   1'b1, 16'sd1,      16'h1234);
      send(CMD_SPEED,   1'b1, -16'sd400,   16'h0000);
      send(CMD_SPEED,   1'b1, -16'sd401,   16'hFFFF);
      // current with reversed and forward motors, unfiltered
      send(CMD_CURRENT, 1'b0, 16'sh7FFF,   16'hFFFF);
      send(CMD_CURRENT, 1'b0, -16'sd32768, 16'h0000);
      send(CMD_CURRENT, 1'b1, 16'sd0,      16'hFFFF);
      send(CMD_SPEED,   1'b1, 16'sd0,      16'h0000);
      send(CMD_CURRENT, 1'b1, 16'shFFFF,   16'hFFFF);
      send(CMD_CURRENT, 1'b1, 16'sd0,      16'h0000);
      send(CMD_SPEED,   1'b0, 16'sd399,    16'h0000);
      send(CMD_CURRENT, 1'b0, 16'sd0,      16'd12345);
      drain();
      // full offsets, gain above one
      configure(17'h1FFFF, 17'h00000, 17'h1FFFF);
      send(CMD_CURRENT, 1'b0, 16'sd0,      16'h0000);
      send(CMD_CURRENT, 1'b0, 16'sd0,      16'hFFFF);
      send(CMD_CURRENT, 1'b1, 16'sd0,      16'h0000);
      drain();
      // gain zero holds the filter
      configure(17'h1FFFF, 17'h00000, 17'h00000);
      send(CMD_CURRENT, 1'b0, 16'sd0,      16'd30000);
      send(CMD_CURRENT, 1'b1, 16'sd0,      16'd100);

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         case (p)
            0:       gain_val = GAIN_ONE;
            1:       gain_val = 17'd1;
            2:       gain_val = 17'h1FFFF;
            3:       gain_val = 17'd0;
            4:       gain_val = CSR_DAT_W'($urandom_range(0, 65536));
            default: gain_val = 17'd32768;
         endcase
         if (p == 0)
            configure(17'd0, 17'hFFFF, gain_val);
         else
            configure(CSR_DAT_W'($urandom), CSR_DAT_W'($urandom), gain_val);
         if (p == N_PHASES - 1) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         if (p == 1) begin
            @(posedge clock);
            long_hold_req = 1'b1;
            @(negedge clock);
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == PHASE_ITEMS / 2)
               drain();
            c = ($urandom_range(0, 9) < 6) ? CMD_CURRENT : CMD_SPEED;
            m = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0: s = SPEED_W'($urandom);
               1: s = SPEED_W'($urandom_range(0, 800)) - 16'd400;
               2: begin
                  case ($urandom_range(0, 6))
                     0:       s = 16'sd0;
                     1:       s = 16'sd400;
                     2:       s = -16'sd401;
                     3:       s = -16'sd32768;
                     4:       s = 16'sd32767;
                     5:       s = -16'sd1;
                     default: s = 16'sd401;
                  endcase
               end
               default: s = SPEED_W'($urandom_range(0, 1000)) - 16'd500;
            endcase
            case ($urandom_range(0, 3))
               0, 1: a = ADC_W'($urandom);
               2:    a = sb.offset[m] + ADC_W'($urandom_range(0, 200)) - 16'd100;
               default: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            send(c, m, s, a);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("result items still outstanding");
      $display("covered %0d drive and %0d current items over %0d register settings",
               sb.n_speed, sb.n_current, n_settings);
      $display("%0d result items checked, %0d mismatches", sb.n_checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("[motor_speed_and_current_filter_core] OK");
      else
         $display("[motor_speed_and_current_filter_core] ERROR");
      $finish;
   end
endmodule
